// ===== src/cbd_pkg.sv =====
package cbd_pkg;

  // Decoder phase, one-hot
  typedef enum logic [2:0] {
    PH_SIZE  = 3'b001,
    PH_DATA  = 3'b010,
    PH_ENDED = 3'b100
  } phase_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BADCHAR   = 3'd1,
    ST_WIDE      = 3'd2,
    ST_PREMATURE = 3'd3,
    ST_TOOLARGE  = 3'd4
  } status_e;

  // Input kind codes
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  localparam int unsigned CHAR_W   = 21;
  localparam int unsigned OFFSET_W = 33;

  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t CHAR_CR = 21'h0D;
  localparam char_t CHAR_LF = 21'h0A;
  localparam char_t CHAR_D0 = 21'h30;
  localparam char_t CHAR_D9 = 21'h39;
  localparam char_t CHAR_LA = 21'h61;
  localparam char_t CHAR_LF_HEX = 21'h66;
  localparam char_t CHAR_UA = 21'h41;
  localparam char_t CHAR_UF = 21'h46;
  localparam char_t BYTE_MAX = 21'hFF;

  // Largest body length: 2^32 bytes
  localparam logic [OFFSET_W-1:0] BODY_LIMIT = 33'h1_0000_0000;

  // Decode a hex digit: bit 4 marks a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_decode(char_t c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= CHAR_D0 && c <= CHAR_D9) begin
      r = {1'b1, 4'(c - CHAR_D0)};
    end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
      r = {1'b1, 4'(c - CHAR_LA + 21'd10)};
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      r = {1'b1, 4'(c - CHAR_UA + 21'd10)};
    end
    return r;
  endfunction

endpackage

// ===== src/chunked_body_decoder_unit.sv =====
// Chunked transfer body decoder, one character per request.
// Pipeline: input register, then result register; a stalled result holds the
// request in the input register. Items that give no result are dropped at the
// second stage.
// Throughput: one input request per cycle while the result stream is not stalled.
// Reset: rst_ni asynchronous, active low; returns to the size-line phase with
// zero size, zero body offset and empty pipeline registers.
module chunked_body_decoder_unit
  import cbd_pkg::*;
#(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // [20:0] char_code, [23:21] zero
  input  logic        s_axis_tuser_i,  // [0] kind
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // [7:0] data_byte, [39:8] body_offset
  output logic [3:0]  m_axis_tuser_o,  // [0] is_data, [3:1] status
  output logic        m_axis_tlast_o   // is_end
);

  localparam int unsigned LIM_W = (SIZE_BITS > OFFSET_W) ? SIZE_BITS : OFFSET_W;

  // Input register
  logic  in_valid_q;
  logic  in_kind_q;
  char_t in_char_q;

  // Decoder state
  phase_e                phase_q, phase_d;
  logic                  digit_q, digit_d;
  logic [SIZE_BITS-1:0]  size_q, size_d;
  logic [SIZE_BITS-1:0]  left_q, left_d;
  logic [OFFSET_W-1:0]   offset_q, offset_d;

  // Result register
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic [31:0] out_offset_q;
  logic        out_data_q;
  logic        out_end_q;
  status_e     out_status_q;

  // Result of the current step
  logic        res_valid;
  logic [7:0]  res_byte;
  logic        res_data;
  logic        res_end;
  status_e     res_status;

  logic             advance;
  logic [4:0]       hex;
  logic [LIM_W-1:0] room;
  logic             too_large;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  assign hex       = hex_decode(in_char_q);
  assign room      = LIM_W'(BODY_LIMIT) - LIM_W'(offset_q);
  assign too_large = LIM_W'(size_q) > room;

  // Capture input requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_kind_q <= s_axis_tuser_i;
      in_char_q <= s_axis_tdata_i[CHAR_W-1:0];
    end
  end

  // Decode one item against the current state
  always_comb begin
    phase_d    = phase_q;
    digit_d    = digit_q;
    size_d     = size_q;
    left_d     = left_q;
    offset_d   = offset_q;
    res_valid  = 1'b0;
    res_byte   = 8'd0;
    res_data   = 1'b0;
    res_end    = 1'b0;
    res_status = ST_OK;

    unique case (phase_q)
      PH_SIZE, PH_DATA: begin
        if (in_kind_q == KIND_EOS) begin
          res_valid  = 1'b1;
          res_end    = 1'b1;
          phase_d    = PH_ENDED;
          res_status = (phase_q == PH_SIZE && size_q == '0) ? ST_OK : ST_PREMATURE;
        end else if (phase_q == PH_DATA) begin
          res_valid = 1'b1;
          if (in_char_q > BYTE_MAX) begin
            res_end    = 1'b1;
            res_status = ST_WIDE;
            phase_d    = PH_ENDED;
          end else begin
            res_byte = in_char_q[7:0];
            res_data = 1'b1;
            offset_d = offset_q + OFFSET_W'(1);
            left_d   = left_q - SIZE_BITS'(1);
            if (left_q == SIZE_BITS'(1)) begin
              phase_d = PH_SIZE;
            end
          end
        end else if (in_char_q == CHAR_CR) begin
          // skip carriage return
        end else if (in_char_q == CHAR_LF) begin
          if (digit_q) begin
            if (size_q == '0) begin
              res_valid = 1'b1;
              res_end   = 1'b1;
              phase_d   = PH_ENDED;
            end else if (too_large) begin
              res_valid  = 1'b1;
              res_end    = 1'b1;
              res_status = ST_TOOLARGE;
              phase_d    = PH_ENDED;
            end else begin
              left_d  = size_q;
              size_d  = '0;
              digit_d = 1'b0;
              phase_d = PH_DATA;
            end
          end
        end else if (!hex[4]) begin
          res_valid  = 1'b1;
          res_end    = 1'b1;
          res_status = ST_BADCHAR;
          phase_d    = PH_ENDED;
        end else if (size_q[SIZE_BITS-1 -: 4] != 4'd0) begin
          res_valid  = 1'b1;
          res_end    = 1'b1;
          res_status = ST_TOOLARGE;
          phase_d    = PH_ENDED;
        end else begin
          size_d  = {size_q[SIZE_BITS-5:0], hex[3:0]};
          digit_d = 1'b1;
        end
      end
      PH_ENDED: begin
        // drop everything after the end
      end
      default: begin
        phase_d = PH_ENDED;
      end
    endcase
  end

  // Advance decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SIZE;
      digit_q  <= 1'b0;
      size_q   <= '0;
      left_q   <= '0;
      offset_q <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      digit_q  <= digit_d;
      size_q   <= size_d;
      left_q   <= left_d;
      offset_q <= offset_d;
    end
  end

  // Hold result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_byte_q   <= res_byte;
      out_offset_q <= offset_q[31:0];
      out_data_q   <= res_data;
      out_end_q    <= res_end;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_offset_q, out_byte_q};
  assign m_axis_tuser_o  = {out_status_q, out_data_q};
  assign m_axis_tlast_o  = out_end_q;

endmodule

// ===== src/cbd_checker.sv =====
module cbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic [3:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  logic        ended_q;
  logic [31:0] next_off_q;
  logic        out_take;

  assign out_take = m_axis_tvalid_o && m_axis_tready_i;

  // Track end of body and expected byte offset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_q    <= 1'b0;
      next_off_q <= '0;
    end else if (out_take) begin
      if (m_axis_tlast_o) begin
        ended_q <= 1'b1;
      end
      if (m_axis_tuser_o[0]) begin
        next_off_q <= next_off_q + 32'd1;
      end
    end
  end

  // No result after the final one
  a_silent_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended_q |-> !m_axis_tvalid_o)
    else $error("result after end of body");

  // Body bytes come at consecutive offsets
  a_offset_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> m_axis_tdata_o[39:8] == next_off_q)
    else $error("body offset out of order");

  // End results carry no byte; non-final results are data bytes with ok status
  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (!m_axis_tuser_o[0] && m_axis_tdata_o[7:0] == 8'd0))
    else $error("end result carries data");

  a_data_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |->
      (m_axis_tuser_o[0] && m_axis_tuser_o[3:1] == 3'd0))
    else $error("non-final result is not a clean data byte");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

endmodule

bind chunked_body_decoder_unit cbd_checker u_cbd_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import cbd_pkg::*;

  localparam int IDLE_LIMIT  = 500;
  localparam int DRAIN_TAIL  = 20;
  localparam int CALM_TAIL   = 120;
  localparam int RANDOM_CHARS = 900;
  localparam int CHAR_TOP    = 1114111;

  // One decoded result, with the block's output fields
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] body_offset;
    logic        is_data;
    logic        is_end;
    status_e     status;
  } body_res_t;

  // One input request; typed rows carry a hand-written expected result
  typedef struct {
    logic      kind;
    char_t     code;
    bit        typed;
    body_res_t want;
  } body_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = KIND_CHAR;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [39:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  body_req_t   body_chars[$];
  body_res_t   decoded_q[$];
  int          cur_idx = 0;
  int          quiet_cycles = 0;
  int          errors = 0;
  bit          calm = 1'b0;
  int          stall_left = 0;

  // Mirror of the decoder state
  phase_e      dec_phase = PH_SIZE;
  bit          dec_seen = 1'b0;
  logic [31:0] dec_size = '0;
  logic [31:0] dec_left = '0;
  logic [32:0] dec_offset = '0;

  chunked_body_decoder_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Hex digit value, or -1 for anything else
  function automatic int hex_val(char_t c);
    if (c >= CHAR_D0 && c <= CHAR_D9) return int'(c - CHAR_D0);
    if (c >= CHAR_LA && c <= CHAR_LF_HEX) return int'(c - CHAR_LA) + 10;
    if (c >= CHAR_UA && c <= CHAR_UF) return int'(c - CHAR_UA) + 10;
    return -1;
  endfunction

  // Advance the decoder mirror by one request; return 1 when it yields a result
  function automatic bit decode_char(input logic kind, input char_t c, output body_res_t r);
    int hv;
    r.data_byte   = 8'h00;
    r.body_offset = dec_offset[31:0];
    r.is_data     = 1'b0;
    r.is_end      = 1'b1;
    r.status      = ST_OK;
    if (dec_phase == PH_ENDED) return 1'b0;
    if (kind == KIND_EOS) begin
      r.status  = (dec_phase == PH_SIZE && dec_size == 0) ? ST_OK : ST_PREMATURE;
      dec_phase = PH_ENDED;
      return 1'b1;
    end
    if (dec_phase == PH_DATA) begin
      if (c > BYTE_MAX) begin
        r.status  = ST_WIDE;
        dec_phase = PH_ENDED;
        return 1'b1;
      end
      r.data_byte = c[7:0];
      r.is_data   = 1'b1;
      r.is_end    = 1'b0;
      dec_offset  = dec_offset + 1;
      dec_left    = dec_left - 1;
      if (dec_left == 0) dec_phase = PH_SIZE;
      return 1'b1;
    end
    // size line
    if (c == CHAR_CR) return 1'b0;
    if (c == CHAR_LF) begin
      if (!dec_seen) return 1'b0;
      if (dec_size == 0) begin
        dec_phase = PH_ENDED;
        return 1'b1;
      end
      if ({1'b0, dec_size} > BODY_LIMIT - dec_offset) begin
        r.status  = ST_TOOLARGE;
        dec_phase = PH_ENDED;
        return 1'b1;
      end
      dec_left  = dec_size;
      dec_size  = '0;
      dec_seen  = 1'b0;
      dec_phase = PH_DATA;
      return 1'b0;
    end
    hv = hex_val(c);
    if (hv < 0) begin
      r.status  = ST_BADCHAR;
      dec_phase = PH_ENDED;
      return 1'b1;
    end
    if (dec_size[31:28] != 0) begin
      r.status  = ST_TOOLARGE;
      dec_phase = PH_ENDED;
      return 1'b1;
    end
    dec_size = {dec_size[27:0], hv[3:0]};
    dec_seen = 1'b1;
    return 1'b0;
  endfunction

  function automatic body_req_t plain(char_t c);
    body_req_t q;
    q.kind  = KIND_CHAR;
    q.code  = c;
    q.typed = 1'b0;
    q.want  = '0;
    return q;
  endfunction

  function automatic body_req_t with_byte(char_t c, logic [31:0] ofs);
    body_req_t q;
    q = plain(c);
    q.typed            = 1'b1;
    q.want.data_byte   = c[7:0];
    q.want.body_offset = ofs;
    q.want.is_data     = 1'b1;
    q.want.is_end      = 1'b0;
    q.want.status      = ST_OK;
    return q;
  endfunction

  function automatic char_t hex_char(logic [3:0] nib);
    if (nib < 10) return CHAR_D0 + char_t'(nib);
    if ($urandom_range(0, 1) != 0) return CHAR_LA + char_t'(nib - 10);
    return CHAR_UA + char_t'(nib - 10);
  endfunction

  task automatic push_char(char_t c);
    body_chars.push_back(plain(c));
  endtask

  task automatic push_eos();
    body_req_t q;
    q = plain(char_t'($urandom_range(0, CHAR_TOP)));
    q.kind = KIND_EOS;
    body_chars.push_back(q);
  endtask

  // Size line: stray CR/LF first, optional leading zeros, mixed-case digits
  task automatic push_size_line(logic [31:0] sz);
    int nd;
    int k;
    int zmax;
    repeat ($urandom_range(0, 2)) push_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
    nd = 1;
    while (nd < 8 && (sz >> (4 * nd)) != 0) nd++;
    zmax = (8 - nd > 2) ? 2 : 8 - nd;
    repeat ($urandom_range(0, zmax)) push_char(CHAR_D0);
    for (k = nd - 1; k >= 0; k--) begin
      push_char(hex_char(sz[4*k +: 4]));
      if ($urandom_range(0, 15) == 0) push_char(CHAR_CR);
    end
    if ($urandom_range(0, 3) != 0) push_char(CHAR_CR);
    push_char(CHAR_LF);
  endtask

  // Body bytes, biased toward the extremes
  task automatic push_data(int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 7);
      if (sel == 0) push_char(char_t'(0));
      else if (sel == 1) push_char(BYTE_MAX);
      else push_char(char_t'($urandom_range(0, 255)));
    end
  endtask

  // Close the body with one randomly chosen terminating sequence
  task automatic push_ending();
    int n;
    char_t c;
    case ($urandom_range(0, 7))
      0: push_size_line(32'h0);
      1: push_eos();
      2: begin
        push_char(hex_char(4'($urandom_range(1, 15))));
        push_eos();
      end
      3: begin
        n = $urandom_range(2, 16);
        push_size_line(n);
        push_data($urandom_range(0, n - 1));
        push_eos();
      end
      4: begin
        do c = char_t'($urandom_range(0, 1) ? $urandom_range(0, 127)
                                           : $urandom_range(0, CHAR_TOP));
        while (hex_val(c) >= 0 || c == CHAR_CR || c == CHAR_LF);
        push_char(c);
      end
      5: begin
        n = $urandom_range(2, 16);
        push_size_line(n);
        push_data($urandom_range(0, n - 1));
        push_char(char_t'($urandom_range(256, CHAR_TOP)));
      end
      6: begin
        push_char(hex_char(4'($urandom_range(1, 15))));
        repeat (8) push_char(hex_char(4'($urandom_range(0, 15))));
      end
      default: push_size_line(32'hFFFF_FFFF);
    endcase
  endtask

  task automatic cmp(string fld, longint unsigned w, longint unsigned a);
    if (w != a) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fld, w, a);
      errors++;
    end
  endtask

  // Check results, then mirror accepted requests
  always @(posedge clk_i) begin
    body_res_t want;
    body_res_t pred;
    body_req_t rq;
    bit produced;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual data %0h tuser %0h last %0b",
                   $time, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          cmp("data_byte", want.data_byte, m_axis_tdata_o[7:0]);
          cmp("body_offset", want.body_offset, m_axis_tdata_o[39:8]);
          cmp("is_data", want.is_data, m_axis_tuser_o[0]);
          cmp("status", want.status, m_axis_tuser_o[3:1]);
          cmp("is_end", want.is_end, m_axis_tlast_o);
        end
      end
      if (s_valid && s_axis_tready_o) begin
        rq = body_chars[cur_idx];
        produced = decode_char(rq.kind, rq.code, pred);
        if (rq.typed) decoded_q.push_back(rq.want);
        else if (produced) decoded_q.push_back(pred);
      end
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result-side backpressure in random bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_ready    <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 10);
      m_ready    <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  initial begin
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    body_req_t dir_tab[18];
    int i;
    int gap;
    int sz;

    // Directed chunks: skipped CR/LF, leading zero, byte extremes, CR/LF as data
    dir_tab = '{
      plain(CHAR_CR), plain(CHAR_LF),
      plain(CHAR_D0), plain(CHAR_D0 + char_t'(2)), plain(CHAR_CR), plain(CHAR_LF),
      with_byte(char_t'(0), 32'd0), with_byte(BYTE_MAX, 32'd1),
      plain(CHAR_LF), plain(CHAR_D0 + char_t'(1)), plain(CHAR_LF),
      with_byte(CHAR_CR, 32'd2),
      plain(CHAR_D0), plain(CHAR_CR), plain(CHAR_D0 + char_t'(1)), plain(CHAR_CR),
      plain(CHAR_LF),
      with_byte(CHAR_LF, 32'd3)
    };
    foreach (dir_tab[k]) body_chars.push_back(dir_tab[k]);

    // Well-formed chunks with random content, then one ending, then ignored noise
    while (body_chars.size() < RANDOM_CHARS) begin
      case ($urandom_range(0, 9))
        0: sz = $urandom_range(65, 200);
        1, 2: sz = $urandom_range(17, 64);
        default: sz = $urandom_range(1, 16);
      endcase
      push_size_line(sz);
      push_data(sz);
    end
    push_ending();
    repeat (30) begin
      if ($urandom_range(0, 1) != 0) push_eos();
      else push_char(char_t'($urandom_range(0, CHAR_TOP)));
    end

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < body_chars.size(); i++) begin
      if (i >= body_chars.size() - CALM_TAIL) calm <= 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 11);
        @(negedge clk_i);
        s_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      s_valid <= 1'b1;
      s_tdata <= {3'b000, body_chars[i].code};
      s_tuser <= body_chars[i].kind;
      cur_idx <= i;
      @(posedge clk_i);
      while (!s_axis_tready_o) @(posedge clk_i);
    end
    @(negedge clk_i);
    s_valid <= 1'b0;

    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_TAIL) @(negedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
